// File: rtl/core/zsap_pkg.sv
package zsap_pkg;

	localparam logic [2:0] OP_BEGIN = 3'd0;
	localparam logic [2:0] OP_NAME  = 3'd1;
	localparam logic [2:0] OP_DATA  = 3'd2;
	localparam logic [2:0] OP_END   = 3'd3;
	localparam logic [2:0] OP_CLOSE = 3'd4;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_NAME = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_DIR  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;

	localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
	localparam logic [31:0] SIG_LOCAL   = 32'h04034b50;
	localparam logic [31:0] SIG_DESC    = 32'h08074b50;
	localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;
	localparam logic [31:0] SIG_END     = 32'h06054b50;
	localparam logic [15:0] FLAG_DESC   = 16'h0008;
	localparam logic [15:0] ZIP_VERSION = 16'd20;

	localparam int HDR_W = 368;

	localparam logic [5:0] LEN_LOCAL   = 6'd30;
	localparam logic [5:0] LEN_DESC    = 6'd16;
	localparam logic [5:0] LEN_CENTRAL = 6'd46;
	localparam logic [5:0] LEN_END     = 6'd22;
	localparam logic [5:0] LEN_BYTE    = 6'd1;

	typedef struct packed {
		logic latch;
		logic prep;
		logic load;
		logic cap;
		logic empty;
	} zsap_cmd_t;

	typedef struct packed {
		logic none_rec;
		logic push_need;
		logic final_byte;
		logic out_free;
	} zsap_sts_t;

	function automatic logic [31:0] crc8_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		end
		return r;
	endfunction

endpackage

// File: rtl/core/zsap_ctrl.sv
module zsap_ctrl
	import zsap_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  zsap_sts_t sts,
	output zsap_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PREP  = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_LOAD  = 3'd3;
	localparam logic [2:0] S_EMPTY = 3'd4;
	localparam logic [2:0] S_GEN   = 3'd5;
	localparam logic [2:0] S_CAP   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_d   = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_WAIT;
			end
			S_WAIT: begin
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = sts.none_rec ? S_EMPTY : S_GEN;
			end
			S_EMPTY: begin
				if (sts.out_free) begin
					cmd.empty = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_GEN: begin
				state_d = S_CAP;
			end
			S_CAP: begin
				if (!sts.push_need || sts.out_free) begin
					cmd.cap = 1'b1;
					state_d = sts.final_byte ? S_IDLE : S_GEN;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/zsap_dp.sv
module zsap_dp
	import zsap_pkg::*;
#(
	parameter int MAX_ENTRIES = 512,
	parameter int NAME_MAX    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  zsap_cmd_t   cmd,
	output zsap_sts_t   sts,
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	output logic        m_tlast,
	output logic        m_tuser
);

	localparam int EW  = $clog2(MAX_ENTRIES + 1);
	localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NLW = $clog2(NAME_MAX + 1);
	localparam int NDEPTH = MAX_ENTRIES * NAME_MAX;
	localparam int NAW = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
	localparam int TW  = 96 + NLW;

	// item
	logic [2:0]  op_q;
	logic [7:0]  bv_q;
	logic [6:0]  nl_q;

	// archive state
	logic [31:0]    crc_q;
	logic [31:0]    eb_q;
	logic [31:0]    so_q;
	logic [31:0]    estart_q;
	logic [EW-1:0]  es_q;
	logic [NLW-1:0] name_left_q;
	logic [NLW-1:0] cur_len_q;
	logic [EW-1:0]  ro_q;
	logic [31:0]    dstart_q;
	logic [31:0]    dsize_q;
	logic [1:0]     phase_q;

	// record emission
	logic [HDR_W-1:0] hdr_q;
	logic [5:0]       hleft_q;
	logic [NLW-1:0]   name_cnt_q;
	logic [NAW-1:0]   nidx_q;
	logic             done_rec_q;
	logic [1:0]       st_q;
	logic [31:0]      acc_q;
	logic [1:0]       cnt_q;

	// output register
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_cnt_q;
	logic        out_last_q;
	logic        out_done_q;
	logic [1:0]  out_st_q;

	// memories
	logic [7:0]    name_mem [NDEPTH];
	logic [TW-1:0] tbl_mem [MAX_ENTRIES];
	logic [7:0]    name_rd_q;
	logic [TW-1:0] tbl_rd_q;

	logic           none_c;
	logic [1:0]     st_c;
	logic           es_full;
	logic           ro_more;
	logic [NLW-1:0] nls;
	logic [NLW-1:0] tlen;
	logic [31:0]    crc_out;
	logic [HDR_W-1:0] hdr_c;
	logic [NAW-1:0] name_wa;
	logic [NAW-1:0] name_base;
	logic           final_c;
	logic           push_c;
	logic [7:0]     byte_c;
	logic [31:0]    word_c;
	logic [IW-1:0]  es_idx;
	logic [IW-1:0]  ro_idx;

	assign es_idx  = es_q[IW-1:0];
	assign ro_idx  = ro_q[IW-1:0];
	assign es_full = (32'(es_q) >= MAX_ENTRIES);
	assign ro_more = (ro_q < es_q);
	assign nls     = (32'(nl_q) > NAME_MAX) ? NLW'(NAME_MAX) : NLW'(nl_q);
	assign tlen    = tbl_rd_q[96 +: NLW];
	assign crc_out = ~crc_q;
	assign name_wa = NAW'(es_idx) * NAW'(NAME_MAX) + NAW'(cur_len_q - name_left_q);
	assign name_base = NAW'(ro_idx) * NAW'(NAME_MAX);

	always_comb begin
		none_c = 1'b0;
		st_c   = ST_OK;
		case (op_q)
			OP_BEGIN: begin
				if (phase_q != PH_IDLE) begin
					none_c = 1'b1;
					st_c   = ST_ORDER;
				end else if (es_full) begin
					none_c = 1'b1;
					st_c   = ST_FULL;
				end
			end
			OP_NAME: begin
				if (phase_q != PH_NAME || name_left_q == '0 || es_full) begin
					none_c = 1'b1;
					st_c   = ST_ORDER;
				end
			end
			OP_DATA: begin
				if (phase_q != PH_DATA) begin
					none_c = 1'b1;
					st_c   = ST_ORDER;
				end
			end
			OP_END: begin
				if (phase_q != PH_DATA || es_full) begin
					none_c = 1'b1;
					st_c   = ST_ORDER;
				end
			end
			OP_CLOSE: begin
				if (phase_q == PH_NAME || phase_q == PH_DATA) begin
					none_c = 1'b1;
					st_c   = ST_ORDER;
				end
			end
			default: begin
				none_c = 1'b1;
			end
		endcase
	end

	always_comb begin
		hdr_c = '0;
		case (op_q)
			OP_BEGIN: begin
				hdr_c = HDR_W'({16'h0, 16'(nls), 96'h0, 48'h0, FLAG_DESC, ZIP_VERSION,
					SIG_LOCAL});
			end
			OP_NAME, OP_DATA: begin
				hdr_c = HDR_W'(bv_q);
			end
			OP_END: begin
				hdr_c = HDR_W'({eb_q, eb_q, crc_out, SIG_DESC});
			end
			OP_CLOSE: begin
				if (ro_more) begin
					hdr_c = {tbl_rd_q[95:64], 32'h0, 64'h0, 16'(tlen), tbl_rd_q[31:0],
						tbl_rd_q[31:0], tbl_rd_q[63:32], 48'h0, FLAG_DESC, ZIP_VERSION,
						ZIP_VERSION, SIG_CENTRAL};
				end else begin
					hdr_c = HDR_W'({16'h0, dstart_q, dsize_q, 16'(es_q), 16'(es_q), 32'h0,
						SIG_END});
				end
			end
			default: begin
				hdr_c = '0;
			end
		endcase
	end

	assign final_c = (hleft_q == 6'd1 && name_cnt_q == '0) ||
		(hleft_q == 6'd0 && name_cnt_q == NLW'(1));
	assign push_c  = final_c || (cnt_q == 2'd3);
	assign byte_c  = (hleft_q != 6'd0) ? hdr_q[7:0] : name_rd_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (2'(i) < cnt_q) begin
				word_c[8*i +: 8] = acc_q[8*i +: 8];
			end else if (2'(i) == cnt_q) begin
				word_c[8*i +: 8] = byte_c;
			end else begin
				word_c[8*i +: 8] = 8'h0;
			end
		end
	end

	assign sts.none_rec   = none_c;
	assign sts.push_need  = push_c;
	assign sts.final_byte = final_c;
	assign sts.out_free   = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b0, out_st_q, out_cnt_q, out_word_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '1;
			eb_q        <= '0;
			so_q        <= '0;
			estart_q    <= '0;
			es_q        <= '0;
			name_left_q <= '0;
			cur_len_q   <= '0;
			ro_q        <= '0;
			dstart_q    <= '0;
			dsize_q     <= '0;
			phase_q     <= PH_IDLE;
			hleft_q     <= '0;
			name_cnt_q  <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((cmd.cap && push_c) || cmd.empty) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.prep && op_q == OP_CLOSE && phase_q == PH_IDLE) begin
				dstart_q <= so_q;
				dsize_q  <= '0;
				ro_q     <= '0;
				phase_q  <= PH_DIR;
			end
			if (cmd.load && !none_c) begin
				name_cnt_q <= (op_q == OP_CLOSE && ro_more) ? tlen : '0;
				cnt_q      <= '0;
				case (op_q)
					OP_BEGIN: begin
						estart_q    <= so_q;
						cur_len_q   <= nls;
						so_q        <= so_q + 32'd30;
						crc_q       <= '1;
						eb_q        <= '0;
						name_left_q <= nls;
						phase_q     <= (nls != '0) ? PH_NAME : PH_DATA;
						hleft_q     <= LEN_LOCAL;
					end
					OP_NAME: begin
						so_q        <= so_q + 32'd1;
						name_left_q <= name_left_q - NLW'(1);
						if (name_left_q == NLW'(1)) begin
							phase_q <= PH_DATA;
						end
						hleft_q <= LEN_BYTE;
					end
					OP_DATA: begin
						crc_q   <= crc8_step(crc_q, bv_q);
						eb_q    <= eb_q + 32'd1;
						so_q    <= so_q + 32'd1;
						hleft_q <= LEN_BYTE;
					end
					OP_END: begin
						es_q    <= es_q + EW'(1);
						so_q    <= so_q + 32'd16;
						phase_q <= PH_IDLE;
						hleft_q <= LEN_DESC;
					end
					OP_CLOSE: begin
						if (ro_more) begin
							dsize_q    <= dsize_q + 32'd46 + 32'(tlen);
							so_q       <= so_q + 32'd46 + 32'(tlen);
							ro_q       <= ro_q + EW'(1);
							hleft_q    <= LEN_CENTRAL;
						end else begin
							crc_q       <= '1;
							eb_q        <= '0;
							so_q        <= '0;
							estart_q    <= '0;
							es_q        <= '0;
							name_left_q <= '0;
							ro_q        <= '0;
							dstart_q    <= '0;
							dsize_q     <= '0;
							phase_q     <= PH_IDLE;
							hleft_q     <= LEN_END;
						end
					end
					default: begin
						hleft_q <= '0;
					end
				endcase
			end
			if (cmd.cap) begin
				if (hleft_q != 6'd0) begin
					hleft_q <= hleft_q - 6'd1;
				end else begin
					name_cnt_q <= name_cnt_q - NLW'(1);
				end
				cnt_q <= push_c ? 2'd0 : cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= s_tdata[2:0];
			bv_q <= s_tdata[10:3];
			nl_q <= s_tdata[17:11];
		end
		if (cmd.load) begin
			st_q       <= st_c;
			done_rec_q <= !none_c && op_q == OP_CLOSE && !ro_more;
			if (!none_c) begin
				hdr_q  <= hdr_c;
				nidx_q <= name_base;
			end
		end
		if (cmd.cap) begin
			acc_q <= word_c;
			if (hleft_q != 6'd0) begin
				hdr_q <= hdr_q >> 8;
			end else begin
				nidx_q <= nidx_q + NAW'(1);
			end
			if (push_c) begin
				out_word_q <= word_c;
				out_cnt_q  <= 3'(cnt_q) + 3'd1;
				out_last_q <= final_c;
				out_done_q <= final_c && done_rec_q;
				out_st_q   <= st_q;
			end
		end
		if (cmd.empty) begin
			out_word_q <= '0;
			out_cnt_q  <= '0;
			out_last_q <= 1'b1;
			out_done_q <= 1'b0;
			out_st_q   <= st_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !none_c && op_q == OP_NAME) begin
			name_mem[name_wa] <= bv_q;
		end
		name_rd_q <= name_mem[nidx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !none_c && op_q == OP_END) begin
			tbl_mem[es_idx] <= {cur_len_q, estart_q, crc_out, eb_q};
		end
		tbl_rd_q <= tbl_mem[ro_idx];
	end

endmodule

// File: rtl/core/zip_stored_archive_packer_top.sv
// Stored ZIP stream packer, data-descriptor mode with CRC-32.
// Input stream s_*: one transaction per item; s_tdata carries the opcode
// (begin, name byte, data byte, end, close), a byte and a name length.
// Output stream m_*: each transaction carries up to four archive bytes,
// first byte lowest, with a byte count and status; m_tlast marks the last
// word of an item and m_tuser marks the word that completes the end record.
// Items are handled one at a time. An item is taken when s_tready is high,
// passes through the prep, wait and load states for decode and table
// lookup, then through a gen and a cap state per output byte from a
// byte-serial header/name generator, or one empty state for a rejected
// item. The table and name memories each have one registered read port,
// which the wait and gen states allow for.
// A finished word waits in an output register; a stall on m_tready holds
// the generator when the next word is ready, and the next item is taken
// while the last word of the previous one still waits.
// Reset clears the archive state; entry tables and name storage are not
// cleared and are only read where written.
module zip_stored_archive_packer_top
	import zsap_pkg::*;
#(
	parameter int MAX_ENTRIES = 512,
	parameter int NAME_MAX    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // opcode[2:0], byte_value[10:3], name_length[17:11]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // out_word[31:0], byte_count[34:32], status[36:35]
	output logic        m_tlast,
	output logic        m_tuser   // archive_done
);

	zsap_cmd_t cmd;
	zsap_sts_t sts;

	zsap_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	zsap_dp #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.NAME_MAX   (NAME_MAX)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("archive done without last");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34:32] == 3'd0 |-> m_tlast && !m_tuser)
		else $error("empty word not a lone last");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[34:32] <= 3'd4)
		else $error("byte count above four");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken during work");

endmodule

// File: test/zip_stored_archive_packer_top_tb.sv
module zip_stored_archive_packer_top_tb;
	import zsap_pkg::*;

	localparam int MAX_ENTRIES = 512;
	localparam int NAME_MAX    = 64;
	localparam int LONG_HOLD_AT = 150;
	localparam int LONG_HOLD    = 700;

	typedef struct {
		logic [2:0] opcode;
		logic [7:0] byte_value;
		logic [6:0] name_length;
		bit         drain;
	} zip_item_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  cnt;
		logic        last;
		logic        done;
		logic [1:0]  status;
	} zip_word_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	zip_stored_archive_packer_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	zip_item_t pending_items[$];
	zip_word_t expected_words[$];
	logic [7:0] zip_bytes[$];
	int errors = 0;
	bit quiet = 0;

	// archive state mirror
	logic [31:0] crc_acc, entry_len, stream_off, entry_off, dir_start, dir_size;
	int          n_entries, name_left, rd_idx;
	logic [1:0]  phase;
	logic [31:0] off_tab[MAX_ENTRIES];
	logic [31:0] crc_tab[MAX_ENTRIES];
	logic [31:0] size_tab[MAX_ENTRIES];
	logic [6:0]  nlen_tab[MAX_ENTRIES];
	logic [7:0]  name_tab[MAX_ENTRIES][NAME_MAX];

	function automatic void clear_archive();
		crc_acc = '1;
		entry_len = 0;
		stream_off = 0;
		entry_off = 0;
		n_entries = 0;
		name_left = 0;
		rd_idx = 0;
		dir_start = 0;
		dir_size = 0;
		phase = PH_IDLE;
	endfunction

	function automatic void put_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			zip_bytes.push_back(8'(64'(v) >> (8*i)));
	endfunction

	function automatic void pack_words(input logic [1:0] st, input logic done);
		zip_word_t w;
		int nw;
		if (zip_bytes.size() == 0) begin
			w = '{32'h0, 3'd0, 1'b1, 1'b0, st};
			expected_words.push_back(w);
			return;
		end
		nw = (zip_bytes.size() + 3) / 4;
		for (int k = 0; k < nw; k++) begin
			w.word = '0;
			w.cnt = '0;
			for (int j = 0; j < 4 && 4*k + j < zip_bytes.size(); j++) begin
				w.word[8*j +: 8] = zip_bytes[4*k + j];
				w.cnt++;
			end
			w.last = (k == nw - 1);
			w.done = (k == nw - 1) ? done : 1'b0;
			w.status = st;
			expected_words.push_back(w);
		end
	endfunction

	function automatic void predict_archive(input logic [2:0] op, input logic [7:0] bv,
		input logic [6:0] nl_in);
		logic [1:0] st;
		logic done;
		logic [6:0] nl;
		int k, len;
		zip_bytes.delete();
		st = ST_OK;
		done = 1'b0;
		nl = nl_in;
		case (op)
			OP_BEGIN: begin
				if (phase != PH_IDLE) st = ST_ORDER;
				else if (n_entries >= MAX_ENTRIES) st = ST_FULL;
				else begin
					if (nl > NAME_MAX) nl = 7'(NAME_MAX);
					entry_off = stream_off;
					nlen_tab[n_entries] = nl;
					put_le(SIG_LOCAL, 4);
					put_le(32'(ZIP_VERSION), 2);
					put_le(32'(FLAG_DESC), 2);
					put_le(0, 6);
					put_le(0, 12);
					put_le(32'(nl), 2);
					put_le(0, 2);
					stream_off += 30;
					crc_acc = '1;
					entry_len = 0;
					name_left = int'(nl);
					phase = (nl > 0) ? PH_NAME : PH_DATA;
				end
			end
			OP_NAME: begin
				if (phase != PH_NAME || name_left == 0 || n_entries >= MAX_ENTRIES) st = ST_ORDER;
				else begin
					k = int'(nlen_tab[n_entries]) - name_left;
					if (k < NAME_MAX) name_tab[n_entries][k] = bv;
					put_le(32'(bv), 1);
					stream_off += 1;
					name_left--;
					if (name_left == 0) phase = PH_DATA;
				end
			end
			OP_DATA: begin
				if (phase != PH_DATA) st = ST_ORDER;
				else begin
					crc_acc ^= {24'h0, bv};
					for (int i = 0; i < 8; i++)
						crc_acc = (crc_acc >> 1) ^ (CRC_POLY & {32{crc_acc[0]}});
					entry_len++;
					stream_off += 1;
					put_le(32'(bv), 1);
				end
			end
			OP_END: begin
				if (phase != PH_DATA || n_entries >= MAX_ENTRIES) st = ST_ORDER;
				else begin
					put_le(SIG_DESC, 4);
					put_le(~crc_acc, 4);
					put_le(entry_len, 4);
					put_le(entry_len, 4);
					off_tab[n_entries] = entry_off;
					crc_tab[n_entries] = ~crc_acc;
					size_tab[n_entries] = entry_len;
					n_entries++;
					stream_off += 16;
					phase = PH_IDLE;
				end
			end
			OP_CLOSE: begin
				if (phase == PH_NAME || phase == PH_DATA) st = ST_ORDER;
				else begin
					if (phase == PH_IDLE) begin
						dir_start = stream_off;
						dir_size = 0;
						rd_idx = 0;
						phase = PH_DIR;
					end
					if (rd_idx < n_entries) begin
						len = int'(nlen_tab[rd_idx]);
						put_le(SIG_CENTRAL, 4);
						put_le(32'(ZIP_VERSION), 2);
						put_le(32'(ZIP_VERSION), 2);
						put_le(32'(FLAG_DESC), 2);
						put_le(0, 6);
						put_le(crc_tab[rd_idx], 4);
						put_le(size_tab[rd_idx], 4);
						put_le(size_tab[rd_idx], 4);
						put_le(len, 2);
						put_le(0, 8);
						put_le(0, 4);
						put_le(off_tab[rd_idx], 4);
						for (int i = 0; i < len; i++)
							put_le(32'(name_tab[rd_idx][i]), 1);
						dir_size += 46 + len;
						stream_off += 46 + len;
						rd_idx++;
					end else begin
						put_le(SIG_END, 4);
						put_le(0, 4);
						put_le(n_entries & 16'hFFFF, 2);
						put_le(n_entries & 16'hFFFF, 2);
						put_le(dir_size, 4);
						put_le(dir_start, 4);
						put_le(0, 2);
						clear_archive();
						done = 1'b1;
					end
				end
			end
			default: ;
		endcase
		pack_words(st, done);
	endfunction

	// stimulus building
	int n_items = 0;

	function automatic void add_item(input logic [2:0] op, input logic [7:0] bv,
		input logic [6:0] nl);
		zip_item_t it;
		it = '{op, bv, nl, 1'b0};
		pending_items.push_back(it);
		n_items++;
	endfunction

	function automatic void add_drain();
		zip_item_t it;
		it = '{OP_BEGIN, 8'h0, 7'h0, 1'b1};
		pending_items.push_back(it);
	endfunction

	function automatic void add_entry(input logic [6:0] nl, input int ndata);
		int nn;
		add_item(OP_BEGIN, 8'($urandom), nl);
		nn = (nl > NAME_MAX) ? NAME_MAX : int'(nl);
		for (int i = 0; i < nn; i++) add_item(OP_NAME, 8'($urandom), 7'($urandom));
		for (int i = 0; i < ndata; i++) add_item(OP_DATA, 8'($urandom), 7'($urandom));
		add_item(OP_END, 8'($urandom), 7'($urandom));
	endfunction

	function automatic void add_closes(input int n);
		for (int i = 0; i < n; i++) add_item(OP_CLOSE, 8'($urandom), 7'($urandom));
	endfunction

	initial begin
		int ne, nl;
		clear_archive();

		// directed
		add_closes(1);
		add_item(OP_NAME, 8'hFF, 7'h7F);
		add_item(OP_DATA, 8'h00, 7'h00);
		add_item(OP_END, 8'h00, 7'h00);
		add_item(3'd5, 8'hFF, 7'h7F);
		add_item(3'd6, 8'h00, 7'h00);
		add_item(3'd7, 8'hA5, 7'h2A);
		add_item(OP_BEGIN, 8'h00, 7'd0);
		add_item(OP_BEGIN, 8'h00, 7'd3);
		add_item(OP_CLOSE, 8'h00, 7'd0);
		add_item(OP_NAME, 8'h11, 7'd0);
		add_item(OP_DATA, 8'hFF, 7'd0);
		add_item(OP_DATA, 8'h00, 7'd0);
		add_item(OP_END, 8'h00, 7'd0);
		add_item(OP_BEGIN, 8'h00, 7'd127);
		for (int i = 0; i < NAME_MAX; i++) add_item(OP_NAME, 8'(i * 4 + 3), 7'd0);
		add_item(OP_NAME, 8'h5A, 7'd0);
		add_item(OP_DATA, 8'h80, 7'd0);
		add_item(OP_END, 8'h00, 7'd0);
		add_entry(7'd64, 2);
		add_closes(5);
		add_drain();

		// random archives with noise
		while (n_items < 460) begin
			ne = $urandom_range(1, 4);
			for (int e = 0; e < ne; e++) begin
				nl = ($urandom_range(0, 15) == 0) ? $urandom_range(64, 127) : $urandom_range(0, 8);
				add_entry(7'(nl), $urandom_range(0, 12));
				if ($urandom_range(0, 9) == 0)
					add_item(3'($urandom_range(0, 7)), 8'($urandom), 7'($urandom));
			end
			add_closes(ne + 1);
			if ($urandom_range(0, 7) == 0)
				add_item(3'($urandom_range(0, 7)), 8'($urandom), 7'($urandom));
			if (n_items > 230 && n_items < 260) add_drain();
		end

		wait (pending_items.size() == 0 && !s_tvalid);
		wait (expected_words.size() == 0);
		repeat (400) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	initial begin
		#30000000;
		$display("*** FAILED ***");
		$finish;
	end

	// sender
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		zip_item_t it;
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_archive(s_tdata[2:0], s_tdata[10:3], s_tdata[17:11]);
			if (!s_tvalid || s_tready) begin
				if ($urandom_range(0, 39) == 0) quiet = !quiet;
				if (gap != 0) begin
					gap <= gap - 1;
					s_tvalid <= 0;
				end else if (pending_items.size() != 0 && pending_items[0].drain) begin
					s_tvalid <= 0;
					if (expected_words.size() == 0) void'(pending_items.pop_front());
				end else if (pending_items.size() != 0) begin
					it = pending_items.pop_front();
					s_tdata <= {6'h0, it.name_length, it.byte_value, it.opcode};
					s_tvalid <= 1;
					gap <= quiet ? 0 : $urandom_range(0, 17);
				end else
					s_tvalid <= 0;
			end
		end
	end

	// receiver
	int stall = 0;
	int n_rx = 0;
	always @(posedge clk or negedge arst_n) begin
		zip_word_t w;
		int st;
		if (!arst_n) begin
			m_tready <= 0;
			stall <= 0;
		end else begin
			st = stall;
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected transaction: out_word %h", m_tdata[31:0]);
					errors++;
				end else begin
					w = expected_words.pop_front();
					if (m_tdata[31:0] !== w.word) begin
						$error("out_word exp %h got %h", w.word, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[34:32] !== w.cnt) begin
						$error("byte_count exp %0d got %0d", w.cnt, m_tdata[34:32]);
						errors++;
					end
					if (m_tdata[36:35] !== w.status) begin
						$error("status exp %0d got %0d", w.status, m_tdata[36:35]);
						errors++;
					end
					if (m_tlast !== w.last) begin
						$error("last exp %0d got %0d", w.last, m_tlast);
						errors++;
					end
					if (m_tuser !== w.done) begin
						$error("archive_done exp %0d got %0d", w.done, m_tuser);
						errors++;
					end
				end
				n_rx++;
				st = quiet ? 0 : $urandom_range(0, 17);
				if (n_rx == LONG_HOLD_AT) st = LONG_HOLD;
			end
			if (st != 0) begin
				m_tready <= 0;
				stall <= st - 1;
			end else
				m_tready <= 1;
		end
	end

endmodule
